FILE: rtl/core/swmm_pkg.sv
// swmm_pkg: shared widths, constants and types of the sliding window min/max/mean block
// no dependencies; used by every file under rtl/core
package swmm_pkg;

    localparam int WIN_DEPTH = 16;
    localparam int DATA_W    = 32;
    localparam int CFG_W     = 5;
    localparam int HELD_W    = 5;
    localparam int SLOT_W    = $clog2(WIN_DEPTH);
    localparam int CNT_W     = $clog2(WIN_DEPTH + 1);
    localparam int SUM_W     = DATA_W + SLOT_W;
    localparam int DCNT_W    = $clog2(SUM_W + 1);

    localparam logic [CFG_W-1:0] MAX_SIZE_RST = CFG_W'(10);

    // one queued request with its window limit resolved at accept time
    typedef struct packed {
        logic signed [DATA_W-1:0] sample;
        logic [CNT_W-1:0]         limit;
    } t_q_item;

    typedef struct packed {
        logic                     start;
        logic signed [SUM_W-1:0]  dividend;
        logic [CNT_W-1:0]         divisor;
    } t_div_req;

    typedef struct packed {
        logic                     done;
        logic signed [DATA_W-1:0] quotient;
    } t_div_rsp;

endpackage

FILE: rtl/core/swmm_if.sv
// swmm_in_if / swmm_out_if: valid-ready channels for samples and window results
// depends on swmm_pkg for field widths
interface swmm_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [swmm_pkg::DATA_W-1:0] sample;

    modport source(output valid, output sample, input ready);
    modport sink(input valid, input sample, output ready);
endinterface

interface swmm_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [swmm_pkg::DATA_W-1:0] window_min;
    logic signed [swmm_pkg::DATA_W-1:0] window_max;
    logic signed [swmm_pkg::DATA_W-1:0] window_mean;
    logic [swmm_pkg::HELD_W-1:0]        held_count;

    modport source(output valid, output window_min, output window_max, output window_mean,
                   output held_count, input ready);
    modport sink(input valid, input window_min, input window_max, input window_mean,
                 input held_count, output ready);
endinterface

FILE: rtl/core/sliding_window_min_max_mean.sv
// sliding_window_min_max_mean: each result waits on the 36-step serial divider, and each
// dropped sample (usually 0 or 1) adds a read and a subtract step before the write; one item
// is in work at a time with up to two more queued, so a new item starts only once the last
// result is loaded. the window scan overlaps the divide. synchronous active-low reset
// empties the window, zeroes the sum and sets max_size to 10. depends on swmm_pkg,
// swmm_if, swmm_front, swmm_back
module sliding_window_min_max_mean (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [swmm_pkg::CFG_W-1:0] i_cfg_wdata,
    swmm_in_if.sink                    i_sample_if,
    swmm_out_if.source                 o_result_if
);
    logic              q_valid;
    logic              q_ready;
    swmm_pkg::t_q_item q_item;

    swmm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_sample_if (i_sample_if),
        .o_q_valid   (q_valid),
        .o_q_item    (q_item),
        .i_q_ready   (q_ready)
    );

    swmm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_q_ready   (q_ready),
        .o_result_if (o_result_if)
    );

endmodule

FILE: rtl/core/swmm_div.sv
// swmm_div: bit-serial signed divide of the running sum by the sample count
// depends on swmm_pkg; one quotient bit per cycle, truncates toward zero
module swmm_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  swmm_pkg::t_div_req i_req,
    output swmm_pkg::t_div_rsp o_rsp
);
    logic                             r_busy;
    logic [swmm_pkg::DCNT_W-1:0]      r_cnt;
    logic [swmm_pkg::SUM_W-1:0]       r_quo;
    logic [swmm_pkg::CNT_W-1:0]       r_rem;
    logic [swmm_pkg::CNT_W-1:0]       r_div;
    logic                             r_neg;

    logic [swmm_pkg::SUM_W-1:0]       mag;
    logic [swmm_pkg::CNT_W:0]         rem_sh;
    logic [swmm_pkg::CNT_W:0]         rem_nx;
    logic                             ge;
    logic [swmm_pkg::DATA_W-1:0]      q_low;

    always_comb begin
        mag    = i_req.dividend[swmm_pkg::SUM_W-1] ? (~i_req.dividend + 1'b1) : i_req.dividend;
        rem_sh = {r_rem, r_quo[swmm_pkg::SUM_W-1]};
        ge     = rem_sh >= {1'b0, r_div};
        rem_nx = ge ? (rem_sh - {1'b0, r_div}) : rem_sh;
        q_low  = r_quo[swmm_pkg::DATA_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= swmm_pkg::DCNT_W'(swmm_pkg::SUM_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == swmm_pkg::DCNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= mag;
            r_rem <= '0;
            r_div <= i_req.divisor;
            r_neg <= i_req.dividend[swmm_pkg::SUM_W-1];
        end else if (r_busy) begin
            r_rem <= rem_nx[swmm_pkg::CNT_W-1:0];
            r_quo <= {r_quo[swmm_pkg::SUM_W-2:0], ge};
        end
    end

    assign o_rsp.done     = !r_busy;
    assign o_rsp.quotient = r_neg ? (~q_low + 1'b1) : q_low;

endmodule

FILE: rtl/core/swmm_front.sv
// swmm_front: takes samples, holds the window size register and tags each request
// with its clamped limit in a two-entry queue; depends on swmm_pkg and swmm_in_if
module swmm_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [swmm_pkg::CFG_W-1:0]  i_cfg_wdata,
    swmm_in_if.sink                     i_sample_if,
    output logic                        o_q_valid,
    output swmm_pkg::t_q_item           o_q_item,
    input  logic                        i_q_ready
);
    logic [swmm_pkg::CFG_W-1:0] r_max_size;
    swmm_pkg::t_q_item          r_q [2];
    logic                       r_wp;
    logic                       r_rp;
    logic [1:0]                 r_cnt;

    logic [swmm_pkg::CNT_W-1:0] lim;
    logic                       push;
    logic                       pop;

    always_comb begin
        if (r_max_size == '0) begin
            lim = swmm_pkg::CNT_W'(1);
        end else if (32'(r_max_size) > 32'(swmm_pkg::WIN_DEPTH)) begin
            lim = swmm_pkg::CNT_W'(swmm_pkg::WIN_DEPTH);
        end else begin
            lim = swmm_pkg::CNT_W'(r_max_size);
        end
    end

    assign i_sample_if.ready = (r_cnt != 2'd2);
    assign push      = i_sample_if.valid && i_sample_if.ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign pop       = o_q_valid && i_q_ready;
    assign o_q_item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_size <= swmm_pkg::MAX_SIZE_RST;
            r_wp       <= 1'b0;
            r_rp       <= 1'b0;
            r_cnt      <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                r_max_size <= i_cfg_wdata;
            end
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp].sample <= i_sample_if.sample;
            r_q[r_wp].limit  <= lim;
        end
    end

endmodule

FILE: rtl/core/swmm_back.sv
// swmm_back: sequencer over the sample ring: drops old samples, writes the new one,
// scans for min and max and collects the mean; depends on swmm_pkg, swmm_out_if, swmm_div
module swmm_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  swmm_pkg::t_q_item i_q_item,
    output logic              o_q_ready,
    swmm_out_if.source        o_result_if
);
    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_DROP_RD  = 3'd1;
    localparam logic [2:0] ST_DROP_SUB = 3'd2;
    localparam logic [2:0] ST_WRITE    = 3'd3;
    localparam logic [2:0] ST_SCAN     = 3'd4;
    localparam logic [2:0] ST_FINISH   = 3'd5;

    logic [2:0]                          r_state;
    logic [2:0]                          n_state;
    logic signed [swmm_pkg::DATA_W-1:0]  r_ring [swmm_pkg::WIN_DEPTH];
    logic signed [swmm_pkg::DATA_W-1:0]  r_rd_data;
    logic [swmm_pkg::SLOT_W-1:0]         r_wslot;
    logic [swmm_pkg::CNT_W-1:0]          r_fill;
    logic signed [swmm_pkg::SUM_W-1:0]   r_sum;
    logic signed [swmm_pkg::SUM_W-1:0]   n_sum;
    logic signed [swmm_pkg::DATA_W-1:0]  r_sample;
    logic [swmm_pkg::CNT_W-1:0]          r_limit;
    logic [swmm_pkg::SLOT_W-1:0]         r_scan_addr;
    logic [swmm_pkg::CNT_W-1:0]          r_scan_left;
    logic                                r_issue;
    logic                                r_first;
    logic signed [swmm_pkg::DATA_W-1:0]  r_lo;
    logic signed [swmm_pkg::DATA_W-1:0]  r_hi;
    logic                                r_out_valid;

    logic [swmm_pkg::SLOT_W-1:0]         rd_addr;
    logic                                mem_we;
    logic                                need_drop;
    logic                                out_free;
    logic                                load_out;
    swmm_pkg::t_div_req                  div_req;
    swmm_pkg::t_div_rsp                  div_rsp;

    swmm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign need_drop = (r_fill >= r_limit) && (r_fill != '0);
    assign out_free  = !r_out_valid || o_result_if.ready;
    assign load_out  = (r_state == ST_FINISH) && div_rsp.done && out_free;
    assign mem_we    = (r_state == ST_WRITE);
    assign o_q_ready = (r_state == ST_IDLE);
    assign n_sum     = r_sum + {{(swmm_pkg::SUM_W-swmm_pkg::DATA_W){r_sample[swmm_pkg::DATA_W-1]}},
                                r_sample};

    assign div_req.start    = (r_state == ST_WRITE);
    assign div_req.dividend = n_sum;
    assign div_req.divisor  = r_fill + 1'b1;

    always_comb begin
        unique case (r_state)
            ST_DROP_RD: rd_addr = r_wslot - r_fill[swmm_pkg::SLOT_W-1:0];
            ST_SCAN:    rd_addr = r_scan_addr;
            default:    rd_addr = '0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) n_state = ST_DROP_RD;
            end
            ST_DROP_RD: begin
                n_state = need_drop ? ST_DROP_SUB : ST_WRITE;
            end
            ST_DROP_SUB: n_state = ST_DROP_RD;
            ST_WRITE:    n_state = ST_SCAN;
            ST_SCAN: begin
                if (r_scan_left == '0 && !r_issue) n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (load_out) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ring storage, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_ring[r_wslot] <= r_sample;
        end
        r_rd_data <= r_ring[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wslot     <= '0;
            r_fill      <= '0;
            r_sum       <= '0;
            r_scan_left <= '0;
            r_issue     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_DROP_SUB) begin
                r_sum  <= r_sum - {{(swmm_pkg::SUM_W-swmm_pkg::DATA_W){r_rd_data[swmm_pkg::DATA_W-1]}},
                                   r_rd_data};
                r_fill <= r_fill - 1'b1;
            end
            if (r_state == ST_WRITE) begin
                r_wslot     <= r_wslot + 1'b1;
                r_fill      <= r_fill + 1'b1;
                r_sum       <= n_sum;
                r_scan_left <= r_fill + 1'b1;
            end
            if (r_state == ST_SCAN) begin
                r_issue <= (r_scan_left != '0);
                if (r_scan_left != '0) begin
                    r_scan_left <= r_scan_left - 1'b1;
                end
            end else begin
                r_issue <= 1'b0;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_result_if.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_q_valid) begin
            r_sample <= i_q_item.sample;
            r_limit  <= i_q_item.limit;
        end
        if (r_state == ST_WRITE) begin
            // new oldest slot is the old write slot minus the old fill
            r_scan_addr <= r_wslot - r_fill[swmm_pkg::SLOT_W-1:0];
            r_first     <= 1'b1;
        end
        if (r_state == ST_SCAN) begin
            if (r_scan_left != '0) begin
                r_scan_addr <= r_scan_addr + 1'b1;
            end
            if (r_issue) begin
                r_first <= 1'b0;
                if (r_first || r_rd_data < r_lo) r_lo <= r_rd_data;
                if (r_first || r_rd_data > r_hi) r_hi <= r_rd_data;
            end
        end
        if (load_out) begin
            o_result_if.window_min  <= r_lo;
            o_result_if.window_max  <= r_hi;
            o_result_if.window_mean <= div_rsp.quotient;
            o_result_if.held_count  <= swmm_pkg::HELD_W'(r_fill);
        end
    end

    assign o_result_if.valid = r_out_valid;

endmodule

FILE: rtl/core/swmm_check.sv
// swmm_check: port-level assertions on the result channel, bound to the top level
// depends on swmm_pkg and sliding_window_min_max_mean
module swmm_check (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_valid,
    input logic                               i_ready,
    input logic signed [swmm_pkg::DATA_W-1:0] i_min,
    input logic signed [swmm_pkg::DATA_W-1:0] i_max,
    input logic signed [swmm_pkg::DATA_W-1:0] i_mean,
    input logic [swmm_pkg::HELD_W-1:0]        i_held
);
    a_held_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_held != '0) && (32'(i_held) <= 32'(swmm_pkg::WIN_DEPTH)))
        else $error("held count out of range");

    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_min <= i_max))
        else $error("window min above max");

    a_mean_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_min <= i_mean) && (i_mean <= i_max))
        else $error("window mean outside min and max");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_min) && $stable(i_max)
            && $stable(i_mean) && $stable(i_held))
        else $error("stalled result changed");

endmodule

bind sliding_window_min_max_mean swmm_check u_swmm_check (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_result_if.valid),
    .i_ready (o_result_if.ready),
    .i_min   (o_result_if.window_min),
    .i_max   (o_result_if.window_max),
    .i_mean  (o_result_if.window_mean),
    .i_held  (o_result_if.held_count)
);

FILE: tb/sv/sliding_window_min_max_mean_tb.sv
`timescale 1ns / 100ps
// sliding_window_min_max_mean_tb: drives samples and window sizes into the block and checks
// every result against a window predictor kept in the bench; depends on swmm_pkg, swmm_if
// and the sliding_window_min_max_mean RTL
module sliding_window_min_max_mean_tb;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 60;

    typedef struct {
        logic signed [swmm_pkg::DATA_W-1:0] lo;
        logic signed [swmm_pkg::DATA_W-1:0] hi;
        logic signed [swmm_pkg::DATA_W-1:0] mean;
        logic [swmm_pkg::HELD_W-1:0]        count;
    } t_window_stats;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [swmm_pkg::CFG_W-1:0] i_cfg_wdata;

    swmm_in_if  sample_bus ();
    swmm_out_if result_bus ();

    sliding_window_min_max_mean u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_sample_if (sample_bus),
        .o_result_if (result_bus)
    );

    always #1 i_clk = ~i_clk;

    // window predictor state
    logic signed [swmm_pkg::DATA_W-1:0] win_ring [swmm_pkg::WIN_DEPTH];
    int                                 win_wr_slot;
    int                                 win_fill;
    longint                             win_sum;
    logic [swmm_pkg::CFG_W-1:0]         win_size_reg;

    t_window_stats pending_stats[$];
    int            error_count = 0;
    int            cycle_count = 0;
    bit            gaps_on = 1'b1;

    function automatic void reset_window_model();
        foreach (win_ring[i]) win_ring[i] = '0;
        win_wr_slot  = 0;
        win_fill     = 0;
        win_sum      = 0;
        win_size_reg = swmm_pkg::MAX_SIZE_RST;
    endfunction

    function automatic t_window_stats advance_window(
        input logic signed [swmm_pkg::DATA_W-1:0] s);
        int            lim;
        int            slot;
        longint        lo;
        longint        hi;
        longint        v;
        t_window_stats r;
        lim = win_size_reg;
        if (lim == 0) lim = 1;
        if (lim > swmm_pkg::WIN_DEPTH) lim = swmm_pkg::WIN_DEPTH;
        // drop oldest samples until the new one fits, several when the size was lowered
        while (win_fill >= lim) begin
            slot = (win_wr_slot + swmm_pkg::WIN_DEPTH - win_fill) % swmm_pkg::WIN_DEPTH;
            win_sum -= longint'(win_ring[slot]);
            win_fill--;
        end
        win_ring[win_wr_slot] = s;
        win_wr_slot = (win_wr_slot + 1) % swmm_pkg::WIN_DEPTH;
        win_fill++;
        win_sum += longint'(s);
        slot = (win_wr_slot + swmm_pkg::WIN_DEPTH - win_fill) % swmm_pkg::WIN_DEPTH;
        lo = win_ring[slot];
        hi = lo;
        for (int i = 1; i < win_fill; i++) begin
            slot = (slot + 1) % swmm_pkg::WIN_DEPTH;
            v = win_ring[slot];
            if (v < lo) lo = v;
            if (v > hi) hi = v;
        end
        r.lo    = lo[swmm_pkg::DATA_W-1:0];
        r.hi    = hi[swmm_pkg::DATA_W-1:0];
        // longint division truncates toward zero
        r.mean  = swmm_pkg::DATA_W'(win_sum / longint'(win_fill));
        r.count = swmm_pkg::HELD_W'(win_fill);
        return r;
    endfunction

    function automatic logic signed [swmm_pkg::DATA_W-1:0] pick_sample();
        logic signed [swmm_pkg::DATA_W-1:0] s;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: s = $urandom;
            4, 5, 6:    s = int'($urandom_range(0, 2000)) - 1000;
            7:          s = (int'($urandom_range(0, 200)) - 100) <<< 16;
            default:    s = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        endcase
        return s;
    endfunction

    // called on a rising edge; returns on the edge where the request is taken
    task automatic send_sample(input logic signed [swmm_pkg::DATA_W-1:0] s);
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            sample_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        sample_bus.valid  <= 1'b1;
        sample_bus.sample <= s;
        do @(posedge i_clk); while (!sample_bus.ready);
        pending_stats.push_back(advance_window(s));
    endtask

    task automatic wait_drained();
        sample_bus.valid <= 1'b0;
        while (pending_stats.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_max_size(input logic [swmm_pkg::CFG_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        win_size_reg = v;
    endtask

    // extremes and sign cases at the reset window size, wrapping past it
    task automatic test_corner_samples();
        logic signed [swmm_pkg::DATA_W-1:0] corners [13];
        corners = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'h1,
                    32'h0001_0000, 32'hFFFF_0000, 32'h5555_5555, 32'hAAAA_AAAA,
                    32'hFFFF_FFFD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000};
        foreach (corners[i]) send_sample(corners[i]);
        wait_drained();
    endtask

    // zero size, one, saturation above depth, and lowering while samples are held
    task automatic test_size_limits();
        write_max_size(swmm_pkg::CFG_W'(0));
        send_sample(32'sd5);
        send_sample(-32'sd7);
        wait_drained();
        write_max_size(swmm_pkg::CFG_W'(1));
        send_sample(32'h4000_0000);
        wait_drained();
        write_max_size(swmm_pkg::CFG_W'(31));
        send_sample(-32'sd1);
        send_sample(32'sd3);
        send_sample(-32'sd4);
        wait_drained();
        write_max_size(swmm_pkg::CFG_W'(2));
        send_sample(32'sd9);
        wait_drained();
    endtask

    task automatic test_random_windows();
        logic [swmm_pkg::CFG_W-1:0] sizes [8];
        logic [swmm_pkg::CFG_W-1:0] sz;
        sizes = '{5'd1, 5'd16, 5'd31, 5'd2, 5'd0, 5'd17, 5'd8, 5'd3};
        for (int phase = 0; phase < 30; phase++) begin
            sz = (phase < 8) ? sizes[phase] : swmm_pkg::CFG_W'($urandom_range(0, 31));
            write_max_size(sz);
            gaps_on = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(40, 80)) send_sample(pick_sample());
            wait_drained();
        end
    endtask

    task automatic test_back_to_back();
        gaps_on = 1'b0;
        write_max_size(swmm_pkg::CFG_W'(16));
        repeat (150) send_sample(pick_sample());
        wait_drained();
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_wdata       <= '0;
        sample_bus.valid  <= 1'b0;
        sample_bus.sample <= '0;
        reset_window_model();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_corner_samples();
        test_size_limits();
        test_random_windows();
        test_back_to_back();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // result side ready, with random stall bursts
    initial begin
        result_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (gaps_on && $urandom_range(0, 5) == 0) begin
                result_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
            result_bus.ready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input logic [swmm_pkg::DATA_W-1:0] exp_v,
                               input logic [swmm_pkg::DATA_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_window_stats want;
        if (i_rst_n && result_bus.valid && result_bus.ready) begin
            if (pending_stats.size() == 0) begin
                $display("%0t: result with no request waiting, expected none actual %h %h %h %h",
                         $time, result_bus.window_min, result_bus.window_max,
                         result_bus.window_mean, result_bus.held_count);
                error_count++;
            end else begin
                want = pending_stats[0];
                pending_stats.delete(0);
                check_field("window_min", want.lo, result_bus.window_min);
                check_field("window_max", want.hi, result_bus.window_max);
                check_field("window_mean", want.mean, result_bus.window_mean);
                check_field("held_count", swmm_pkg::DATA_W'(want.count),
                            swmm_pkg::DATA_W'(result_bus.held_count));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

endmodule

FILE: files.f
rtl/core/swmm_pkg.sv
rtl/core/swmm_if.sv
rtl/core/swmm_div.sv
rtl/core/swmm_front.sv
rtl/core/swmm_back.sv
rtl/core/sliding_window_min_max_mean.sv
rtl/core/swmm_check.sv
tb/sv/sliding_window_min_max_mean_tb.sv
